/* rtl/tpsb_pkg.sv */
`timescale 1ns / 1ps

package tpsb_pkg;

    // Field widths fixed by the interface
    localparam int SLOT_W  = 2;
    localparam int LEN_W   = 16;
    localparam int OFF_W   = 16;
    localparam int PT_W    = 15;
    localparam int SIGN_W  = 2;
    localparam int CNT_W   = 4;
    localparam int BATCH_W = 8;
    localparam int UNIT_W  = BATCH_W + 1;
    localparam int REM_W   = BATCH_W;
    localparam int BIT_W   = 4;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic CMD_FLIP  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic signed [SIGN_W-1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [SIGN_W-1:0] SIGN_NEG  = 2'sb11;
    localparam logic signed [SIGN_W-1:0] SIGN_NONE = 2'sb00;

    // Register index (paddr bit 2)
    localparam logic REG_BATCH = 1'b0;
    localparam logic REG_FMODE = 1'b1;

    localparam logic [BATCH_W-1:0] BATCH_RST = 8'd1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic scan_step;
        logic move_init;
        logic move_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic slot_ok;
        logic div_last;
        logic scan_done;
        logic move_ok;
        logic move_done;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/tpsb_req_if.sv */
`timescale 1ns / 1ps

interface tpsb_req_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [tpsb_pkg::SLOT_W-1:0]      slot;
    logic [tpsb_pkg::LEN_W-1:0]       length_bytes;
    logic [tpsb_pkg::OFF_W-1:0]       offset;

    modport source (output valid, cmd, slot, length_bytes, offset, input ready);
    modport sink   (input valid, cmd, slot, length_bytes, offset, output ready);
endinterface

/* rtl/tpsb_rsp_if.sv */
`timescale 1ns / 1ps

interface tpsb_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [tpsb_pkg::SIGN_W-1:0] sign;
    logic [tpsb_pkg::CNT_W-1:0]         point_count;
    logic                               overflow;

    modport source (output valid, sign, point_count, overflow, input ready);
    modport sink   (input valid, sign, point_count, overflow, output ready);
endinterface

/* rtl/tpsb_ctrl.sv */
`timescale 1ns / 1ps

module tpsb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tpsb_pkg::t_dp_sts i_sts,
    output tpsb_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_DIV    = 6'b000100,
        S_SCAN   = 6'b001000,
        S_MOVE   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_sts.slot_ok) begin
                    n_state = S_FINISH;
                end else if (i_sts.is_query) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.is_query || !i_sts.move_ok) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.move_init = 1'b1;
                        n_state         = S_MOVE;
                    end
                end
            end
            S_MOVE: begin
                o_cmd.move_step = 1'b1;
                if (i_sts.move_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/tpsb_datapath.sv */
`timescale 1ns / 1ps

module tpsb_datapath #(
    parameter int SLOT_COUNT = 4,
    parameter int MAX_POINTS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tpsb_pkg::t_dp_cmd                  i_cmd,
    output tpsb_pkg::t_dp_sts                  o_sts,
    input  logic                               i_req_cmd,
    input  logic [tpsb_pkg::SLOT_W-1:0]        i_req_slot,
    input  logic [tpsb_pkg::LEN_W-1:0]         i_req_len,
    input  logic [tpsb_pkg::OFF_W-1:0]         i_req_off,
    input  logic [tpsb_pkg::BATCH_W-1:0]       i_batch,
    input  logic                               i_fmode,
    output logic                               o_rsp_valid,
    input  logic                               i_rsp_ready,
    output logic signed [tpsb_pkg::SIGN_W-1:0] o_rsp_sign,
    output logic [tpsb_pkg::CNT_W-1:0]         o_rsp_count,
    output logic                               o_rsp_ovf
);

    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int DEPTH = SLOT_COUNT * MAX_POINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SIW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int PT_W   = tpsb_pkg::PT_W;
    localparam int REM_W  = tpsb_pkg::REM_W;
    localparam int UNIT_W = tpsb_pkg::UNIT_W;
    localparam int BIT_W  = tpsb_pkg::BIT_W;
    localparam int CNT_W  = tpsb_pkg::CNT_W;
    localparam int SIGN_W = tpsb_pkg::SIGN_W;

    function automatic logic [AW-1:0] f_addr(input logic [tpsb_pkg::SLOT_W-1:0] slot,
                                             input logic [CW-1:0] idx);
        return AW'(32'(slot) * MAX_POINTS + 32'(idx));
    endfunction

    // Per-slot state
    logic [CW-1:0]              r_cnt [SLOT_COUNT];
    logic                       r_neg [SLOT_COUNT];
    logic [PT_W-1:0]            r_mem [DEPTH];
    logic [PT_W-1:0]            r_rdata;

    // Item registers
    logic                       r_op;
    logic [tpsb_pkg::SLOT_W-1:0] r_slot;
    logic [PT_W-1:0]            r_half;
    logic [tpsb_pkg::OFF_W-1:0] r_off;
    logic [REM_W-1:0]           r_rem;
    logic [BIT_W-1:0]           r_bit;
    logic [CW-1:0]              r_idx;
    logic [CW-1:0]              r_pidx;
    logic [CW-1:0]              r_left;
    logic [CW-1:0]              r_acc;
    logic                       r_rv;
    logic                       r_par;
    logic                       r_found;
    logic                       r_del;
    logic                       r_mv;

    // Output register
    logic                       r_ovalid;
    logic signed [SIGN_W-1:0]   r_osign;
    logic [CNT_W-1:0]           r_ocnt;
    logic                       r_oovf;

    logic [SIW-1:0]             w_sidx;
    logic                       w_slot_ok;
    logic [CW-1:0]              w_n;
    logic                       w_sneg;
    logic                       w_full;
    logic [UNIT_W-1:0]          w_unit;
    logic [UNIT_W-1:0]          w_trial;
    logic [PT_W-1:0]            w_point;
    logic                       w_rd_en;
    logic                       w_mv_wr;
    logic                       w_put_wr;
    logic [CW-1:0]              w_wr_idx;
    logic [PT_W-1:0]            w_wr_data;
    logic                       w_out_free;
    logic [CW-1:0]              w_new_n;

    assign w_sidx    = SIW'(r_slot);
    assign w_slot_ok = (32'(r_slot) < SLOT_COUNT);
    assign w_n       = r_cnt[w_sidx];
    assign w_sneg    = r_neg[w_sidx];
    assign w_full    = (32'(w_n) >= MAX_POINTS);

    // Rounding unit: batch size, or batch size plus one; zero counts as one
    always_comb begin
        if (i_fmode) begin
            w_unit = {1'b0, i_batch} + UNIT_W'(1);
        end else if (i_batch == '0) begin
            w_unit = UNIT_W'(1);
        end else begin
            w_unit = {1'b0, i_batch};
        end
    end

    assign w_trial = {r_rem, r_half[r_bit]};
    assign w_point = r_half - PT_W'(r_rem);

    assign w_rd_en   = (i_cmd.scan_step && (r_idx != w_n)) ||
                       (i_cmd.move_step && (r_left != '0));
    assign w_mv_wr   = i_cmd.move_step && r_rv;
    assign w_put_wr  = i_cmd.finish && r_mv && !r_del;
    assign w_wr_idx  = w_mv_wr ? (r_del ? r_pidx - CW'(1) : r_pidx + CW'(1)) : r_acc;
    assign w_wr_data = w_mv_wr ? r_rdata : w_point;
    assign w_new_n   = r_del ? w_n - CW'(1) : w_n + CW'(1);
    assign w_out_free = !r_ovalid || i_rsp_ready;

    always_comb begin
        o_sts           = '0;
        o_sts.is_query  = (r_op == tpsb_pkg::CMD_QUERY);
        o_sts.slot_ok   = w_slot_ok;
        o_sts.div_last  = (r_bit == '0);
        o_sts.scan_done = (r_idx == w_n) && !r_rv;
        o_sts.move_ok   = r_found || !w_full;
        o_sts.move_done = (r_left == '0) && !r_rv;
        o_sts.out_free  = w_out_free;
    end

    // Point memory
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[f_addr(r_slot, r_idx)];
        end
        if (w_mv_wr || w_put_wr) begin
            r_mem[f_addr(r_slot, w_wr_idx)] <= w_wr_data;
        end
    end

    // Item payload, divider, scan and move counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req_cmd;
            r_slot <= i_req_slot;
            r_half <= i_req_len[tpsb_pkg::LEN_W-1:1];
            r_off  <= i_req_off;
            r_rem  <= '0;
            r_bit  <= BIT_W'(PT_W - 1);
            r_idx  <= '0;
            r_acc  <= '0;
            r_left <= '0;
            r_par  <= 1'b0;
            r_found <= 1'b0;
            r_del  <= 1'b0;
        end else if (i_cmd.div_step) begin
            if (w_trial >= w_unit) begin
                r_rem <= REM_W'(w_trial - w_unit);
            end else begin
                r_rem <= REM_W'(w_trial);
            end
            r_bit <= r_bit - BIT_W'(1);
        end else if (i_cmd.move_init) begin
            r_del <= r_found;
            if (r_found) begin
                r_idx  <= r_acc + CW'(1);
                r_left <= w_n - CW'(1) - r_acc;
            end else begin
                r_idx  <= w_n - CW'(1);
                r_left <= w_n - r_acc;
            end
        end else if (i_cmd.scan_step) begin
            if (r_idx != w_n) begin
                r_idx <= r_idx + CW'(1);
            end
            if (r_rv) begin
                if (r_op == tpsb_pkg::CMD_QUERY) begin
                    if (r_off >= {1'b0, r_rdata}) begin
                        r_par <= ~r_par;
                    end
                end else begin
                    if (r_rdata < w_point) begin
                        r_acc <= r_acc + CW'(1);
                    end
                    if (r_rdata == w_point) begin
                        r_found <= 1'b1;
                    end
                end
            end
        end else if (i_cmd.move_step) begin
            if (r_left != '0) begin
                r_pidx <= r_idx;
                r_idx  <= r_del ? r_idx + CW'(1) : r_idx - CW'(1);
                r_left <= r_left - CW'(1);
            end
        end
    end

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv     <= 1'b0;
            r_mv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_mv <= 1'b0;
            end else if (i_cmd.move_init) begin
                r_mv <= 1'b1;
            end

            if (i_cmd.move_init || i_cmd.load) begin
                r_rv <= 1'b0;
            end else if (i_cmd.scan_step || i_cmd.move_step) begin
                r_rv <= w_rd_en;
            end

            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Slot counts and sign bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                r_cnt[s] <= '0;
                r_neg[s] <= 1'b0;
            end
        end else if (i_cmd.finish && r_mv) begin
            r_cnt[w_sidx] <= w_new_n;
            r_neg[w_sidx] <= ~w_sneg;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (!w_slot_ok) begin
                r_osign <= tpsb_pkg::SIGN_NONE;
                r_ocnt  <= '0;
                r_oovf  <= 1'b0;
            end else if (r_op == tpsb_pkg::CMD_QUERY) begin
                r_osign <= (w_sneg ^ r_par) ? tpsb_pkg::SIGN_NEG : tpsb_pkg::SIGN_POS;
                r_ocnt  <= CNT_W'(w_n);
                r_oovf  <= 1'b0;
            end else if (r_mv) begin
                r_osign <= w_sneg ? tpsb_pkg::SIGN_POS : tpsb_pkg::SIGN_NEG;
                r_ocnt  <= CNT_W'(w_new_n);
                r_oovf  <= 1'b0;
            end else begin
                r_osign <= w_sneg ? tpsb_pkg::SIGN_NEG : tpsb_pkg::SIGN_POS;
                r_ocnt  <= CNT_W'(w_n);
                r_oovf  <= 1'b1;
            end
        end
    end

    assign o_rsp_valid = r_ovalid;
    assign o_rsp_sign  = r_osign;
    assign o_rsp_count = r_ocnt;
    assign o_rsp_ovf   = r_oovf;

endmodule

/* rtl/turning_point_state_bit_table.sv */
`timescale 1ns / 1ps

// Turning-point sign table. Holds, per buffer slot, an ascending list of turning
// points and a sign bit.
// Channels: i_req carries one command per transfer (cmd, slot, length_bytes,
// offset); o_rsp returns exactly one result per command (sign, point_count,
// overflow). Both use valid/ready; a transfer happens when both are high.
// Configuration: APB write of the jobs-per-batch count at 0x0 and footprint_mode
// at 0x4. Write only while no command is in flight. pready is tied high.
// Steps from request transfer to result valid, n being the slot's point count:
// a query runs decide, n reads plus a drain of the read pipeline, and finish.
// A flip adds a bit-serial remainder unit for the rounding and a shift step
// that moves m points with one read and one write each (no move on overflow).
// One command is worked on at a time: i_req.ready is high only while idle,
// so the next command is taken only after the last one has finished.
// Stall: a result held by a low o_rsp.ready does not block the next request;
// a new result waits in the finish step until the output register is free.
// Reset (synchronous, active low): all slots empty with positive sign,
// jobs-per-batch count 1, footprint_mode 0, no result pending.
module turning_point_state_bit_table #(
    parameter int SLOT_COUNT = 4,
    parameter int MAX_POINTS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tpsb_req_if.sink                          i_req,
    tpsb_rsp_if.source                        o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tpsb_pkg::APB_AW-1:0]       paddr,
    input  logic [tpsb_pkg::APB_DW-1:0]       pwdata,
    output logic [tpsb_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    logic [tpsb_pkg::BATCH_W-1:0] r_batch;
    logic                         r_fmode;
    logic                         w_reg_sel;
    logic                         w_cfg_wr;

    tpsb_pkg::t_dp_cmd            w_cmd;
    tpsb_pkg::t_dp_sts            w_sts;

    // Register file: the index sits at paddr bit 2
    assign w_reg_sel = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch <= tpsb_pkg::BATCH_RST;
            r_fmode <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_sel)
                tpsb_pkg::REG_BATCH: r_batch <= pwdata[tpsb_pkg::BATCH_W-1:0];
                tpsb_pkg::REG_FMODE: r_fmode <= pwdata[0];
                default: begin
                    r_batch <= r_batch;
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            tpsb_pkg::REG_BATCH: prdata = tpsb_pkg::APB_DW'(r_batch);
            tpsb_pkg::REG_FMODE: prdata = tpsb_pkg::APB_DW'(r_fmode);
            default:             prdata = '0;
        endcase
    end

    // Sequencer: walks decide, divide, scan, move and finish steps
    tpsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Point memory, slot state, remainder unit and result register
    tpsb_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req_cmd   (i_req.cmd),
        .i_req_slot  (i_req.slot),
        .i_req_len   (i_req.length_bytes),
        .i_req_off   (i_req.offset),
        .i_batch     (r_batch),
        .i_fmode     (r_fmode),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_sign  (o_rsp.sign),
        .o_rsp_count (o_rsp.point_count),
        .o_rsp_ovf   (o_rsp.overflow)
    );

endmodule

/* rtl/tpsb_checker.sv */
`timescale 1ns / 1ps

module tpsb_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_req_valid,
    input logic                               i_req_ready,
    input logic                               i_rsp_valid,
    input logic                               i_rsp_ready,
    input logic signed [tpsb_pkg::SIGN_W-1:0] i_rsp_sign,
    input logic [tpsb_pkg::CNT_W-1:0]         i_rsp_count,
    input logic                               i_rsp_ovf
);

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_sign) &&
        $stable(i_rsp_count) && $stable(i_rsp_ovf))
        else $error("result changed while stalled");

    // One command in flight: ready drops after a request transfer
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    // A new result only comes out of a busy period
    a_rsp_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(!i_req_ready))
        else $error("result without work");

    // An overflow result carries a real sign
    a_ovf_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_ovf |->
        (i_rsp_sign == tpsb_pkg::SIGN_POS) || (i_rsp_sign == tpsb_pkg::SIGN_NEG))
        else $error("overflow result with zero sign");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

endmodule

bind turning_point_state_bit_table tpsb_checker u_tpsb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_sign  (o_rsp.sign),
    .i_rsp_count (o_rsp.point_count),
    .i_rsp_ovf   (o_rsp.overflow)
);
